### design/pgrep_pkg.sv
// Shared constants and types for the page replacement frame table.
// No dependencies; imported by pgrep_scan, the top level and the testbench.
`timescale 1ns / 1ps

package pgrep_pkg;

  localparam int FRAMES_DEF     = 16;
  localparam int PAGE_WIDTH_DEF = 20;

  localparam int COUNT_W     = 16;
  localparam int FAULT_W     = 32;
  localparam int FRAME_OUT_W = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

  localparam logic POLICY_LRU = 1'b0;
  localparam logic POLICY_LFU = 1'b1;

  localparam logic [CFG_DATA_W-1:0] FRAMES_IN_USE_RST = 5'd16;

  // status of a finished lookup scan
  typedef struct packed {
    logic match_found;
    logic empty_found;
  } scan_flags_t;

endpackage

### design/pgrep_frame_ram.sv
// Frame table storage: one write port, one read port, registered read data.
// Depends on nothing; entry layout is set by the top level.
`timescale 1ns / 1ps

module pgrep_frame_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [AW-1:0]                    raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pgrep_scan.sv
// Lookup scan: takes one frame entry per cycle on ingest and tracks the first match,
// the first empty frame and the LRU and LFU victim candidates. Uses pgrep_pkg.
`timescale 1ns / 1ps

module pgrep_scan #(
  parameter int FRAMES     = 16,
  parameter int PAGE_WIDTH = 20,
  parameter int FIDX_W     = 4
) (
  input  logic                        clk,
  input  logic                        clear,
  input  logic                        ingest,
  input  logic [FIDX_W-1:0]           idx,
  input  logic                        ent_valid,
  input  logic [PAGE_WIDTH-1:0]       ent_page,
  input  logic [FIDX_W-1:0]           ent_rank,
  input  logic [pgrep_pkg::COUNT_W-1:0] ent_count,
  input  logic [PAGE_WIDTH-1:0]       req_page,
  output pgrep_pkg::scan_flags_t      flags,
  output logic [FIDX_W-1:0]           match_idx,
  output logic [FIDX_W-1:0]           match_rank,
  output logic [FIDX_W-1:0]           empty_idx,
  output logic [FIDX_W-1:0]           lru_idx,
  output logic [FIDX_W-1:0]           lru_rank,
  output logic [PAGE_WIDTH-1:0]       lru_page,
  output logic [FIDX_W-1:0]           lfu_idx,
  output logic [FIDX_W-1:0]           lfu_rank,
  output logic [PAGE_WIDTH-1:0]       lfu_page
);
  import pgrep_pkg::*;

  scan_flags_t          flags_r;
  logic [FIDX_W-1:0]    match_idx_r, match_rank_r, empty_idx_r;
  logic [FIDX_W-1:0]    lru_idx_r, lru_rank_r, lfu_idx_r, lfu_rank_r;
  logic [PAGE_WIDTH-1:0] lru_page_r, lfu_page_r;
  logic [COUNT_W-1:0]   lfu_count_r;
  logic                 first;

  assign first = (idx == '0);

  always_ff @(posedge clk) begin
    if (clear) begin
      flags_r <= '0;
    end else if (ingest) begin
      if (!flags_r.match_found && ent_valid && ent_page == req_page) begin
        flags_r.match_found <= 1'b1;
        match_idx_r         <= idx;
        match_rank_r        <= ent_rank;
      end
      if (!flags_r.empty_found && !ent_valid) begin
        flags_r.empty_found <= 1'b1;
        empty_idx_r         <= idx;
      end
      // strict compares keep the lowest index on ties
      if (first || ent_rank > lru_rank_r) begin
        lru_idx_r  <= idx;
        lru_rank_r <= ent_rank;
        lru_page_r <= ent_page;
      end
      if (first || ent_count < lfu_count_r) begin
        lfu_idx_r   <= idx;
        lfu_count_r <= ent_count;
        lfu_rank_r  <= ent_rank;
        lfu_page_r  <= ent_page;
      end
    end
  end

  assign flags      = flags_r;
  assign match_idx  = match_idx_r;
  assign match_rank = match_rank_r;
  assign empty_idx  = empty_idx_r;
  assign lru_idx    = lru_idx_r;
  assign lru_rank   = lru_rank_r;
  assign lru_page   = lru_page_r;
  assign lfu_idx    = lfu_idx_r;
  assign lfu_rank   = lfu_rank_r;
  assign lfu_page   = lfu_page_r;

endmodule

### design/page_replacement_lru_lfu.sv
// Page replacement frame table with LRU or LFU eviction: control FSM,
// recency sweep and result registers. Uses pgrep_pkg, pgrep_frame_ram, pgrep_scan.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-------------------------
//  request | in_page_number                           | start & !busy
//  result  | out_hit out_frame_index out_evicted_*    | out_valid, one cycle
//          | out_fault_count                          |
//  config  | cfg_index cfg_data                       | cfg_valid & cfg_ready
//
// A request runs a lookup pass that reads the n active frames one per cycle through the
// frame RAM port, n being the active frame count, then a recency pass that rewrites all
// FRAMES entries. busy is high after accept and falls in the same cycle that out_valid
// rises; one request at a time. Reset (synchronous, rst_n low) empties all frames,
// clears the fault total and sets LRU with 16 active frames. The receiver cannot
// stall results.
`timescale 1ns / 1ps

module page_replacement_lru_lfu #(
  parameter int FRAMES     = pgrep_pkg::FRAMES_DEF,
  parameter int PAGE_WIDTH = pgrep_pkg::PAGE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [PAGE_WIDTH-1:0]                in_page_number,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [pgrep_pkg::FRAME_OUT_W-1:0]    out_frame_index,
  output logic                                 out_evicted_valid,
  output logic [PAGE_WIDTH-1:0]                out_evicted_page,
  output logic [pgrep_pkg::FAULT_W-1:0]        out_fault_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pgrep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pgrep_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pgrep_pkg::*;

  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int ENT_W  = PAGE_WIDTH + FIDX_W + COUNT_W;
  localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAMES - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_WAIT_S = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_TOUCH  = 6'b010000,
    ST_WAIT_T = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic                     policy_r;
  logic [CFG_DATA_W-1:0]    fiu_r;
  logic                     valid_r [FRAMES];

  logic [FIDX_W-1:0]        addr_r, addr_nxt;
  logic [FIDX_W-1:0]        last_r;
  logic                     rd_vld_r;
  logic [FIDX_W-1:0]        rd_idx_r;
  logic [PAGE_WIDTH-1:0]    page_r;

  logic [FIDX_W-1:0]        target_r, old_rank_r;
  logic                     was_valid_r, hit_r;
  logic [FAULT_W-1:0]       fault_r;

  logic                     out_valid_r, out_hit_r, out_ev_valid_r;
  logic [FRAME_OUT_W-1:0]   out_frame_r;
  logic [PAGE_WIDTH-1:0]    out_ev_page_r;

  logic                     accept;
  logic [FIDX_W-1:0]        n_last;
  logic [ENT_W-1:0]         rdata, wdata;
  logic                     we;
  logic [PAGE_WIDTH-1:0]    rd_page, wr_page;
  logic [FIDX_W-1:0]        rd_rank, wr_rank;
  logic [COUNT_W-1:0]       rd_count, wr_count;
  logic                     ingest;

  scan_flags_t              flags;
  logic [FIDX_W-1:0]        match_idx, match_rank, empty_idx;
  logic [FIDX_W-1:0]        lru_idx, lru_rank, lfu_idx, lfu_rank;
  logic [PAGE_WIDTH-1:0]    lru_page, lfu_page;

  logic [FIDX_W-1:0]        dec_target, dec_old_rank;
  logic                     dec_was_valid, dec_ev_valid;
  logic [PAGE_WIDTH-1:0]    dec_ev_page;
  logic [FIDX_W+FRAME_OUT_W-1:0] target_ext;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // active frame count clamped to 1..FRAMES, kept as last index
  always_comb begin
    if (fiu_r == '0) begin
      n_last = '0;
    end else if (int'(fiu_r) > FRAMES) begin
      n_last = LAST_FRAME;
    end else begin
      n_last = FIDX_W'(int'(fiu_r) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_LRU;
      fiu_r    <= FRAMES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLICY_SELECT: policy_r <= cfg_data[0];
        CFG_FRAMES_IN_USE: fiu_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  pgrep_frame_ram #(
    .DEPTH (FRAMES),
    .WIDTH (ENT_W),
    .AW    (FIDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (rd_idx_r),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign rd_page  = rdata[ENT_W-1 -: PAGE_WIDTH];
  assign rd_rank  = rdata[COUNT_W +: FIDX_W];
  assign rd_count = rdata[COUNT_W-1:0];

  assign ingest = rd_vld_r && (state_r == ST_SCAN || state_r == ST_WAIT_S);

  pgrep_scan #(
    .FRAMES     (FRAMES),
    .PAGE_WIDTH (PAGE_WIDTH),
    .FIDX_W     (FIDX_W)
  ) u_scan (
    .clk        (clk),
    .clear      (accept),
    .ingest     (ingest),
    .idx        (rd_idx_r),
    .ent_valid  (valid_r[rd_idx_r]),
    .ent_page   (rd_page),
    .ent_rank   (rd_rank),
    .ent_count  (rd_count),
    .req_page   (page_r),
    .flags      (flags),
    .match_idx  (match_idx),
    .match_rank (match_rank),
    .empty_idx  (empty_idx),
    .lru_idx    (lru_idx),
    .lru_rank   (lru_rank),
    .lru_page   (lru_page),
    .lfu_idx    (lfu_idx),
    .lfu_rank   (lfu_rank),
    .lfu_page   (lfu_page)
  );

  // frame choice once the lookup pass is complete
  always_comb begin
    dec_ev_valid = 1'b0;
    dec_ev_page  = '0;
    if (flags.match_found) begin
      dec_target    = match_idx;
      dec_old_rank  = match_rank;
      dec_was_valid = 1'b1;
    end else if (flags.empty_found) begin
      dec_target    = empty_idx;
      dec_old_rank  = '0;
      dec_was_valid = 1'b0;
    end else if (policy_r == POLICY_LFU) begin
      dec_target    = lfu_idx;
      dec_old_rank  = lfu_rank;
      dec_was_valid = 1'b1;
      dec_ev_valid  = 1'b1;
      dec_ev_page   = lfu_page;
    end else begin
      dec_target    = lru_idx;
      dec_old_rank  = lru_rank;
      dec_was_valid = 1'b1;
      dec_ev_valid  = 1'b1;
      dec_ev_page   = lru_page;
    end
  end

  // recency sweep: read-modify-write of every entry, one per cycle
  assign we = rd_vld_r && (state_r == ST_TOUCH || state_r == ST_WAIT_T);

  always_comb begin
    wr_page  = rd_page;
    wr_rank  = rd_rank;
    wr_count = rd_count;
    if (rd_idx_r == target_r) begin
      wr_rank = '0;
      if (hit_r) begin
        wr_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
      end else begin
        wr_page  = page_r;
        wr_count = COUNT_W'(1);
      end
    end else if (valid_r[rd_idx_r] && (!was_valid_r || rd_rank < old_rank_r)
                 && rd_rank < LAST_FRAME) begin
      wr_rank = rd_rank + 1'b1;
    end
  end

  assign wdata = {wr_page, wr_rank, wr_count};

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
          addr_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (addr_r == last_r) begin
          state_nxt = ST_WAIT_S;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_WAIT_S: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = ST_TOUCH;
        addr_nxt  = '0;
      end
      ST_TOUCH: begin
        if (addr_r == LAST_FRAME) begin
          state_nxt = ST_WAIT_T;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_WAIT_T: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fault_r     <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == ST_SCAN) || (state_r == ST_TOUCH);
      out_valid_r <= (state_r == ST_WAIT_T);
      if (state_r == ST_DECIDE) begin
        valid_r[dec_target] <= 1'b1;
        if (!flags.match_found && fault_r != FAULT_MAX) begin
          fault_r <= fault_r + 1'b1;
        end
      end
    end
  end

  assign target_ext = {{FRAME_OUT_W{1'b0}}, dec_target};

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    rd_idx_r <= addr_r;
    if (accept) begin
      page_r <= in_page_number;
      last_r <= n_last;
    end
    if (state_r == ST_DECIDE) begin
      target_r       <= dec_target;
      old_rank_r     <= dec_old_rank;
      was_valid_r    <= dec_was_valid;
      hit_r          <= flags.match_found;
      out_hit_r      <= flags.match_found;
      out_frame_r    <= target_ext[FRAME_OUT_W-1:0];
      out_ev_valid_r <= dec_ev_valid;
      out_ev_page_r  <= dec_ev_page;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_count   = fault_r;

endmodule

### tb/tb_page_replacement_lru_lfu.sv
// Self-checking testbench for page_replacement_lru_lfu: directed table, then randomized
// page streams over several policy / active-frame settings, checked by an in-bench frame
// table model. Depends on design/pgrep_pkg.sv and design/page_replacement_lru_lfu.sv.
`timescale 1ns / 1ps

module tb_page_replacement_lru_lfu;
  import pgrep_pkg::*;

  localparam int NF = FRAMES_DEF;
  localparam int PW = PAGE_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 2 * NF + 8;
  localparam int NUM_PHASES = 13;
  localparam int PHASE_ITEMS = 149;
  localparam int POOL_SIZE = 24;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic               hit;
    logic [3:0]         frame;
    logic               ev_valid;
    logic [PW-1:0]      ev_page;
    logic [FAULT_W-1:0] faults;
  } lookup_t;

  typedef enum logic {ROW_ACCESS, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PW-1:0]         page;
    logic                  typed;
    lookup_t               exp;
  } dir_row_t;

  localparam lookup_t NO_EXP = '0;
  localparam int NUM_DIR = 24;

  // typed expectations only where they follow directly from reset / two-frame LRU
  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h00000, 1'b1, '{1'b0, 4'd0, 1'b0, 20'h0, 32'd1}},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'hFFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 20'h0, 32'd2}},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h00000, 1'b1, '{1'b1, 4'd0, 1'b0, 20'h0, 32'd2}},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'hFFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 20'h0, 32'd2}},
    '{ROW_REG, CFG_FRAMES_IN_USE, 5'd2, 20'h0, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h12345, 1'b1,
      '{1'b0, 4'd0, 1'b1, 20'h00000, 32'd3}},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h00000, 1'b1,
      '{1'b0, 4'd1, 1'b1, 20'hFFFFF, 32'd4}},
    '{ROW_REG, CFG_POLICY_SELECT, {4'd0, POLICY_LFU}, 20'h0, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h12345, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h77777, 1'b0, NO_EXP},
    // zero active frames behaves as one
    '{ROW_REG, CFG_FRAMES_IN_USE, 5'd0, 20'h0, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h0F0F0, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h0F0F0, 1'b0, NO_EXP},
    // oversize count clamps to the table; undecoded indexes must be dropped
    '{ROW_REG, CFG_FRAMES_IN_USE, 5'd31, 20'h0, 1'b0, NO_EXP},
    '{ROW_REG, CFG_SPARE_A, 5'd31, 20'h0, 1'b0, NO_EXP},
    '{ROW_REG, CFG_SPARE_B, 5'd0, 20'h0, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h77777, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'hAAAAA, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h55555, 1'b0, NO_EXP},
    '{ROW_REG, CFG_FRAMES_IN_USE, 5'd16, 20'h0, 1'b0, NO_EXP},
    '{ROW_REG, CFG_POLICY_SELECT, {4'd0, POLICY_LRU}, 20'h0, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h80000, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'h00001, 1'b0, NO_EXP},
    '{ROW_ACCESS, CFG_POLICY_SELECT, 5'd0, 20'hFFFFE, 1'b0, NO_EXP}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [PW-1:0] in_page_number = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy, out_valid, out_hit, out_evicted_valid, cfg_ready;
  logic [FRAME_OUT_W-1:0] out_frame_index;
  logic [PW-1:0] out_evicted_page;
  logic [FAULT_W-1:0] out_fault_count;

  page_replacement_lru_lfu u_top (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_page_number(in_page_number),
    .out_valid(out_valid), .out_hit(out_hit), .out_frame_index(out_frame_index),
    .out_evicted_valid(out_evicted_valid), .out_evicted_page(out_evicted_page),
    .out_fault_count(out_fault_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame table model state
  logic [PW-1:0]      tbl_page  [NF];
  logic               tbl_valid [NF];
  logic [3:0]         tbl_rank  [NF];
  logic [COUNT_W-1:0] tbl_uses  [NF];
  logic [FAULT_W-1:0] fault_total;
  logic               cur_policy;
  logic [CFG_DATA_W-1:0] cur_frames;

  lookup_t pending_lookups [$];
  int errors = 0;
  logic [PW-1:0] page_pool [POOL_SIZE];

  function automatic int active_count();
    if (cur_frames == 0) return 1;
    if (cur_frames > NF) return NF;
    return int'(cur_frames);
  endfunction

  function automatic void refresh_recency(int f);
    logic was_valid;
    logic [3:0] old_rank;
    was_valid = tbl_valid[f];
    old_rank = tbl_rank[f];
    for (int i = 0; i < NF; i++) begin
      if (i != f && tbl_valid[i] && (!was_valid || tbl_rank[i] < old_rank) &&
          tbl_rank[i] < 4'(NF - 1))
        tbl_rank[i] = tbl_rank[i] + 4'd1;
    end
    tbl_rank[f] = '0;
  endfunction

  function automatic lookup_t access_frame_table(logic [PW-1:0] page);
    lookup_t r;
    int n, f;
    bit found;
    r = '0;
    n = active_count();
    f = 0;
    found = 1'b0;
    for (int i = 0; i < n && !found; i++) begin
      if (tbl_valid[i] && tbl_page[i] == page) begin
        f = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      refresh_recency(f);
      if (tbl_uses[f] != COUNT_MAX) tbl_uses[f] = tbl_uses[f] + 1'b1;
    end else begin
      if (fault_total != FAULT_MAX) fault_total = fault_total + 1'b1;
      for (int i = 0; i < n && !found; i++) begin
        if (!tbl_valid[i]) begin
          f = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        f = 0;
        for (int i = 1; i < n; i++) begin
          if (cur_policy == POLICY_LFU) begin
            if (tbl_uses[i] < tbl_uses[f]) f = i;
          end else if (tbl_rank[i] > tbl_rank[f]) begin
            f = i;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page = tbl_page[f];
      end
      refresh_recency(f);
      tbl_page[f] = page;
      tbl_valid[f] = 1'b1;
      tbl_uses[f] = COUNT_W'(1);
    end
    r.frame = 4'(f);
    r.faults = fault_total;
    return r;
  endfunction

  // result monitor; outputs sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    lookup_t e;
    if (rst_n && out_valid) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result, frame_index %0d hit %0b", $time,
                 out_frame_index, out_hit);
        errors++;
      end else begin
        e = pending_lookups.pop_front();
        if (out_hit !== e.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, e.hit, out_hit);
          errors++;
        end
        if (out_frame_index !== e.frame) begin
          $display("%0t: frame_index exp %0d got %0d", $time, e.frame, out_frame_index);
          errors++;
        end
        if (out_evicted_valid !== e.ev_valid) begin
          $display("%0t: evicted_valid exp %0b got %0b", $time, e.ev_valid,
                   out_evicted_valid);
          errors++;
        end
        if (out_evicted_page !== e.ev_page) begin
          $display("%0t: evicted_page exp %h got %h", $time, e.ev_page, out_evicted_page);
          errors++;
        end
        if (out_fault_count !== e.faults) begin
          $display("%0t: fault_count exp %0d got %0d", $time, e.faults, out_fault_count);
          errors++;
        end
      end
    end
  end

  // one request; start stays high afterwards only when the next one follows at once
  task automatic issue(input logic [PW-1:0] page, input int gap, input bit keep_start,
                       input bit gap_after_idle, input bit typed, input lookup_t typed_exp);
    lookup_t r;
    start <= 1'b1;
    in_page_number <= page;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = access_frame_table(page);
    pending_lookups.push_back(typed ? typed_exp : r);
    if (!keep_start) start <= 1'b0;
    if (gap > 0) begin
      in_page_number <= PW'($urandom);
      if (gap_after_idle) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_POLICY_SELECT) cur_policy = data[0];
    else if (idx == CFG_FRAMES_IN_USE) cur_frames = data;
    if (!keep_valid) cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] frames_list [NUM_PHASES];
    logic pol;
    bit keep, after_idle, need_settle;
    int gap, k;
    logic [PW-1:0] pg;

    frames_list = '{5'd16, 5'd16, 5'd1, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd20, 5'd15,
                    5'd0, 5'd0, 5'd16};
    frames_list[10] = 5'($urandom_range(1, 16));
    frames_list[11] = 5'($urandom_range(0, 31));

    for (int i = 0; i < NF; i++) begin
      tbl_page[i] = '0;
      tbl_valid[i] = 1'b0;
      tbl_rank[i] = '0;
      tbl_uses[i] = '0;
    end
    fault_total = '0;
    cur_policy = POLICY_LRU;
    cur_frames = FRAMES_IN_USE_RST;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PW'($urandom);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    need_settle = 1'b0;
    for (int r = 0; r < NUM_DIR; r++) begin
      keep = (r + 1 < NUM_DIR) && (dir_rows[r + 1].kind == dir_rows[r].kind);
      if (dir_rows[r].kind == ROW_REG) begin
        if (need_settle) settle();
        need_settle = 1'b0;
        write_reg(dir_rows[r].idx, dir_rows[r].data, keep);
      end else begin
        issue(dir_rows[r].page, 0, keep, 1'b0, dir_rows[r].typed, dir_rows[r].exp);
        need_settle = 1'b1;
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      pol = ph[0];
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  5'($urandom_range(0, 31)), 1'b1);
      write_reg(CFG_POLICY_SELECT, {4'd0, pol}, 1'b1);
      write_reg(CFG_FRAMES_IN_USE, frames_list[ph], 1'b0);
      // a few fresh pages each phase; enough pool entries to force evictions
      for (int j = 0; j < 4; j++) page_pool[$urandom_range(0, POOL_SIZE - 1)] = PW'($urandom);
      k = active_count() + int'($urandom_range(1, 6));
      if (k > POOL_SIZE) k = POOL_SIZE;
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        if ($urandom_range(0, 99) < 85) pg = page_pool[$urandom_range(0, k - 1)];
        else pg = PW'($urandom);
        gap = 0;
        after_idle = 1'b0;
        if (ph != NUM_PHASES - 1 && $urandom_range(0, 3) == 0) begin
          gap = int'($urandom_range(1, 8));
          after_idle = 1'($urandom_range(0, 1));
        end
        keep = (gap == 0) && (it + 1 < PHASE_ITEMS);
        issue(pg, gap, keep, after_idle, 1'b0, NO_EXP);
      end
    end

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
